/* hdl/sfs_pkg.sv */
package sfs_pkg;

	localparam int SLOTS        = 64;
	localparam int SLOT_FIELD_W = 6;
	localparam int IDX_W        = $clog2(SLOTS);
	localparam int CNT_W        = $clog2(SLOTS + 1);
	localparam int GRP          = 8;
	localparam int GRP_W        = $clog2(GRP);
	localparam int NGRP         = (SLOTS + GRP - 1) / GRP;
	localparam int PAD          = NGRP * GRP;

	typedef enum logic {
		FUNC_ALLOC = 1'b0,
		FUNC_FREE  = 1'b1
	} sfs_func_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_DEAD = 2'd2
	} sfs_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN,
		S_RESP
	} sfs_state_t;

	typedef struct packed {
		logic do_free;
		logic pop_start;
		logic pop_grant;
		logic hw_grant;
		logic scan_start;
		logic scan_grant;
	} sfs_cmd_t;

	typedef struct packed {
		logic stack_nonempty;
		logic hw_avail;
	} sfs_stat_t;

endpackage

/* hdl/sfs_if.sv */
interface sfs_req_if;
	import sfs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    func;
	logic [SLOT_FIELD_W-1:0] slot_in;

	modport source (output valid, output func, output slot_in, input ready);
	modport sink   (input valid, input func, input slot_in, output ready);
endinterface

interface sfs_rsp_if;
	import sfs_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [1:0]              status;
	logic [SLOT_FIELD_W-1:0] slot_out;

	modport source (output valid, output status, output slot_out, input ready);
	modport sink   (input valid, input status, input slot_out, output ready);
endinterface

/* hdl/slot_allocator_free_stack_top.sv */
// A free, or a fresh slot from the high-water counter, is registered straight into
// the result; a pop from the freed stack (registered stack memory read) or a
// bitmap scan (two-stage priority search) passes through S_POP or S_SCAN first.
// One request in flight: a new request is taken the cycle after the result is
// taken, so a response stall also holds off the next request.
// arst_n clears all alive marks, the high-water counter and the stack depth.
module slot_allocator_free_stack_top (
	input logic  clk,
	input logic  arst_n,
	sfs_req_if.sink   req,
	sfs_rsp_if.source rsp
);
	import sfs_pkg::*;

	sfs_cmd_t    cmd;
	sfs_stat_t   stat;
	sfs_status_t res_status;
	logic [SLOT_FIELD_W-1:0] res_slot;

	sfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	sfs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.slot_in    (req.slot_in),
		.stat       (stat),
		.res_status (res_status),
		.res_slot   (res_slot)
	);

	assign rsp.status   = res_status;
	assign rsp.slot_out = res_slot;

endmodule

/* hdl/sfs_ctrl.sv */
module sfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_func,
	input  logic              rsp_ready,
	input  sfs_pkg::sfs_stat_t stat,
	output logic              req_ready,
	output logic              rsp_valid,
	output sfs_pkg::sfs_cmd_t  cmd
);
	import sfs_pkg::*;

	sfs_state_t state_q;
	sfs_state_t state_d;
	logic       is_free;

	assign is_free = (sfs_func_t'(req_func) == FUNC_FREE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (is_free || !stat.stack_nonempty && stat.hw_avail) begin
						state_d = S_RESP;
					end else if (stat.stack_nonempty) begin
						state_d = S_POP;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_POP:  state_d = S_RESP;
			S_SCAN: state_d = S_RESP;
			S_RESP: begin
				if (rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (is_free) begin
						cmd.do_free = 1'b1;
					end else if (stat.stack_nonempty) begin
						cmd.pop_start = 1'b1;
					end else if (stat.hw_avail) begin
						cmd.hw_grant = 1'b1;
					end else begin
						cmd.scan_start = 1'b1;
					end
				end
			end
			S_POP:  cmd.pop_grant  = 1'b1;
			S_SCAN: cmd.scan_grant = 1'b1;
			S_RESP: rsp_valid      = 1'b1;
			default: ;
		endcase
	end

endmodule

/* hdl/sfs_dp.sv */
module sfs_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sfs_pkg::sfs_cmd_t               cmd,
	input  logic [sfs_pkg::SLOT_FIELD_W-1:0] slot_in,
	output sfs_pkg::sfs_stat_t              stat,
	output sfs_pkg::sfs_status_t            res_status,
	output logic [sfs_pkg::SLOT_FIELD_W-1:0] res_slot
);
	import sfs_pkg::*;

	logic [SLOTS-1:0] alive_q;
	logic [CNT_W-1:0] hw_q;
	logic [CNT_W-1:0] depth_q;
	logic [IDX_W-1:0] stack_mem [SLOTS];
	logic [IDX_W-1:0] rd_q;

	logic             grp_any_s1   [NGRP];
	logic [GRP_W-1:0] grp_first_s1 [NGRP];

	sfs_status_t             res_status_q;
	logic [SLOT_FIELD_W-1:0] res_slot_q;

	logic [IDX_W-1:0] free_idx;
	logic             free_ok;
	logic             push_ok;
	logic [PAD-1:0]   clear_v;
	logic             grp_any   [NGRP];
	logic [GRP_W-1:0] grp_first [NGRP];
	logic             scan_found;
	logic [IDX_W-1:0] scan_idx;
	logic             set_en;
	logic [IDX_W-1:0] set_idx;

	assign free_idx = IDX_W'(slot_in);
	assign free_ok  = (32'(slot_in) < 32'(SLOTS)) && alive_q[free_idx];
	assign push_ok  = depth_q < CNT_W'(SLOTS);

	assign stat.stack_nonempty = (depth_q != '0);
	assign stat.hw_avail       = hw_q < CNT_W'(SLOTS);

	// Pad the bitmap so slots past the pool never look free.
	always_comb begin
		for (int i = 0; i < PAD; i++) begin
			if (i < SLOTS) begin
				clear_v[i] = ~alive_q[i];
			end else begin
				clear_v[i] = 1'b0;
			end
		end
	end

	// First stage: lowest clear bit inside each group of eight.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any[g]   = 1'b0;
			grp_first[g] = '0;
			for (int b = GRP - 1; b >= 0; b--) begin
				if (clear_v[g * GRP + b]) begin
					grp_any[g]   = 1'b1;
					grp_first[g] = GRP_W'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			for (int g = 0; g < NGRP; g++) begin
				grp_any_s1[g]   <= grp_any[g];
				grp_first_s1[g] <= grp_first[g];
			end
		end
	end

	// Second stage: lowest group with a clear bit.
	always_comb begin
		scan_found = 1'b0;
		scan_idx   = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				scan_found = 1'b1;
				scan_idx   = IDX_W'(g * GRP + int'(grp_first_s1[g]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_free && free_ok && push_ok) begin
			stack_mem[IDX_W'(depth_q)] <= free_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_start) begin
			rd_q <= stack_mem[IDX_W'(depth_q - 1'b1)];
		end
	end

	always_comb begin
		set_en  = 1'b0;
		set_idx = '0;
		if (cmd.pop_grant) begin
			set_en  = 1'b1;
			set_idx = rd_q;
		end else if (cmd.hw_grant) begin
			set_en  = 1'b1;
			set_idx = IDX_W'(hw_q);
		end else if (cmd.scan_grant && scan_found) begin
			set_en  = 1'b1;
			set_idx = scan_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
			hw_q    <= '0;
			depth_q <= '0;
		end else begin
			if (set_en) begin
				alive_q[set_idx] <= 1'b1;
			end
			if (cmd.do_free && free_ok) begin
				alive_q[free_idx] <= 1'b0;
				if (push_ok) begin
					depth_q <= depth_q + 1'b1;
				end
			end
			if (cmd.pop_start) begin
				depth_q <= depth_q - 1'b1;
			end
			if (cmd.hw_grant) begin
				hw_q <= hw_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_free) begin
			res_status_q <= free_ok ? ST_DONE : ST_DEAD;
			res_slot_q   <= slot_in;
		end else if (set_en) begin
			res_status_q <= ST_DONE;
			res_slot_q   <= SLOT_FIELD_W'(set_idx);
		end else if (cmd.scan_grant) begin
			res_status_q <= ST_FULL;
			res_slot_q   <= '0;
		end
	end

	assign res_status = res_status_q;
	assign res_slot   = res_slot_q;

endmodule

/* hdl/sfs_checker.sv */
module sfs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_status,
	input logic [5:0] rsp_slot_out
);
	import sfs_pkg::*;

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot_out))
		else $error("result changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in flight");

	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while a result is pending");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_slot_out == '0)
		else $error("full result carries a slot");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |=> !rsp_valid)
		else $error("result repeated");

endmodule

bind slot_allocator_free_stack_top sfs_checker u_sfs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_slot_out (rsp.slot_out)
);
